@@ rtl/cmc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_pkg
// Shared types, constants and calendar helpers for the calendar minute
// converter.
// ----------------------------------------------------------------------------
package cmc_pkg;

    localparam int unsigned CMC_BLOCK_YEARS_DEF = 1000;
    localparam int unsigned CMC_MAX_YEAR        = 9999;
    localparam int unsigned CMC_MIN_PER_DAY     = 1440;
    localparam int unsigned CMC_MIN_PER_HOUR    = 60;
    localparam int unsigned CMC_YEAR_MIN_COMMON = 525600;
    localparam int unsigned CMC_YEAR_MIN_LEAP   = 527040;
    localparam logic [32:0] CMC_LIMIT_MINUTES   = 33'd5258964960;

    // cumulative days before each month, common and leap years
    localparam logic [8:0] CMC_CUM_DAYS [2][13] = '{
        '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
          9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365},
        '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
          9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366}
    };

    typedef struct packed {
        logic        kind;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [32:0] total_minutes;
    } t_cmc_in;

    typedef struct packed {
        logic [32:0] minutes_count;
        logic [13:0] date_year;
        logic [3:0]  date_month;
        logic [4:0]  date_day;
        logic [4:0]  date_hour;
        logic [5:0]  date_minute;
        logic        range_error;
    } t_cmc_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BLOCK,
        S_YEAR,
        S_MONTH,
        S_DAY,
        S_HOUR,
        S_FINISH
    } t_cmc_state;

    typedef struct packed {
        logic load;
        logic blk_step;
        logic year_init;
        logic year_step;
        logic mon_add;
        logic mon_step;
        logic dhm_add;
        logic day_step;
        logic hour_step;
        logic finish;
        logic finish_err;
    } t_cmc_cmd;

    typedef struct packed {
        logic kind;
        logic range_err;
        logic blk_more;
        logic year_more;
        logic mon_more;
        logic day_more;
        logic hour_more;
    } t_cmc_sts;

    // minutes from the start of year 1 to the start of year y, elaboration only
    function automatic logic [32:0] cmc_block_offset(input longint unsigned y);
        longint unsigned n;
        n = y - 1;
        return 33'((365 * n + n / 4 - n / 100 + n / 400) * 1440);
    endfunction

    function automatic longint unsigned cmc_block_start(input longint unsigned k,
                                                        input longint unsigned b);
        longint unsigned s;
        s = k * b;
        return (s < 1) ? 1 : s;
    endfunction

    // minutes before month idx (0 based count of whole months)
    function automatic logic [19:0] cmc_cum_min(input logic leap, input logic [3:0] idx);
        logic [3:0] i;
        i = (idx > 4'd12) ? 4'd12 : idx;
        return 20'(CMC_CUM_DAYS[leap][i]) * 20'(CMC_MIN_PER_DAY);
    endfunction

    // minutes in month m (1 to 12)
    function automatic logic [19:0] cmc_mon_min(input logic leap, input logic [3:0] m);
        logic [3:0] i;
        i = (m < 4'd1) ? 4'd1 : ((m > 4'd12) ? 4'd12 : m);
        return cmc_cum_min(leap, i) - cmc_cum_min(leap, i - 4'd1);
    endfunction

endpackage

@@ rtl/cmc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_ctrl
// Sequencer for the converter: block scan, year stepping, month, day and
// hour phases, then result load; a range error ends the block scan early.
// ----------------------------------------------------------------------------
module cmc_ctrl
    import cmc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_cmc_sts i_sts,
    output t_cmc_cmd o_cmd
);

    t_cmc_state r_state;
    t_cmc_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_BLOCK;
                end
            end
            S_BLOCK: begin
                if (i_sts.kind && i_sts.range_err) begin
                    o_cmd.finish_err = 1'b1;
                    n_state          = S_IDLE;
                end else if (i_sts.blk_more) begin
                    o_cmd.blk_step = 1'b1;
                end else begin
                    o_cmd.year_init = 1'b1;
                    n_state         = S_YEAR;
                end
            end
            S_YEAR: begin
                if (i_sts.year_more) begin
                    o_cmd.year_step = 1'b1;
                end else begin
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                if (!i_sts.kind) begin
                    o_cmd.mon_add = 1'b1;
                    n_state       = S_DAY;
                end else if (i_sts.mon_more) begin
                    o_cmd.mon_step = 1'b1;
                end else begin
                    n_state = S_DAY;
                end
            end
            S_DAY: begin
                if (!i_sts.kind) begin
                    o_cmd.dhm_add = 1'b1;
                    n_state       = S_FINISH;
                end else if (i_sts.day_more) begin
                    o_cmd.day_step = 1'b1;
                end else begin
                    n_state = S_HOUR;
                end
            end
            S_HOUR: begin
                if (i_sts.hour_more) begin
                    o_cmd.hour_step = 1'b1;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/cmc_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_dp
// Datapath: minute accumulator, year counter with leap tracking, block
// offset table, month/day/hour counters and the result register.
// ----------------------------------------------------------------------------
module cmc_dp
    import cmc_pkg::*;
#(
    parameter int unsigned BLOCK_YEARS = CMC_BLOCK_YEARS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cmc_in  i_item,
    input  t_cmc_cmd i_cmd,
    output t_cmc_sts o_sts,
    output logic     o_done,
    output t_cmc_out o_result
);

    localparam int unsigned NBLK  = CMC_MAX_YEAR / BLOCK_YEARS + 2;
    localparam int unsigned KW    = $clog2(NBLK);
    localparam int unsigned B_M100 = BLOCK_YEARS % 100;
    localparam int unsigned B_M400 = BLOCK_YEARS % 400;

    // offset of the first year of each block
    logic [32:0] w_blk_off [NBLK];
    for (genvar g = 0; g < NBLK; g++) begin : g_blk
        assign w_blk_off[g] = cmc_block_offset(
            cmc_block_start(longint'(g), longint'(BLOCK_YEARS)));
    end

    logic        r_kind;
    logic [13:0] r_yin;
    logic [3:0]  r_min;
    logic [4:0]  r_din;
    logic [4:0]  r_hin;
    logic [5:0]  r_mnin;
    logic [32:0] r_acc;
    logic [13:0] r_base;
    logic [KW-1:0] r_k;
    logic [13:0] r_c;
    logic [6:0]  r_m100;
    logic [8:0]  r_m400;
    logic [3:0]  r_mon;
    logic [4:0]  r_day;
    logic [4:0]  r_hr;
    logic        r_done;
    t_cmc_out    r_res;
    t_cmc_out    n_res;

    logic [14:0] w_base_nxt;
    logic [7:0]  w_m100_sum;
    logic [9:0]  w_m400_sum;
    logic        w_leap;
    logic [19:0] w_ym;
    logic [19:0] w_mlen;
    logic [32:0] w_off_next;
    logic [32:0] w_dhm;

    assign w_base_nxt = {1'b0, r_base} + 15'(BLOCK_YEARS);
    assign w_m100_sum = {1'b0, r_m100} + 8'(B_M100);
    assign w_m400_sum = {1'b0, r_m400} + 10'(B_M400);
    assign w_leap     = ((r_c[1:0] == 2'd0) && (r_m100 != 7'd0)) || (r_m400 == 9'd0);
    assign w_ym       = w_leap ? 20'(CMC_YEAR_MIN_LEAP) : 20'(CMC_YEAR_MIN_COMMON);
    assign w_mlen     = cmc_mon_min(w_leap, r_mon);
    assign w_off_next = w_blk_off[KW'(r_k + 1'b1)];
    assign w_dhm      = 33'(({28'd0, r_din} - 33'd1) * 33'(CMC_MIN_PER_DAY))
                      + 33'({28'd0, r_hin} * 33'(CMC_MIN_PER_HOUR))
                      + {27'd0, r_mnin};

    always_comb begin
        o_sts.kind      = r_kind;
        o_sts.range_err = (r_acc >= CMC_LIMIT_MINUTES);
        if (!r_kind) begin
            o_sts.blk_more  = (w_base_nxt <= {1'b0, r_yin});
            o_sts.year_more = (r_c < r_yin);
        end else begin
            o_sts.blk_more  = (w_base_nxt <= 15'(CMC_MAX_YEAR)) && (w_off_next <= r_acc);
            o_sts.year_more = (r_c < 14'(CMC_MAX_YEAR)) && (r_acc >= 33'(w_ym));
        end
        o_sts.mon_more  = (r_mon < 4'd12) && (r_acc >= 33'(w_mlen));
        o_sts.day_more  = (r_acc >= 33'(CMC_MIN_PER_DAY));
        o_sts.hour_more = (r_acc >= 33'(CMC_MIN_PER_HOUR));
    end

    always_comb begin
        n_res = r_res;
        if (i_cmd.finish) begin
            n_res = '0;
            if (!r_kind) begin
                n_res.minutes_count = r_acc;
            end else begin
                n_res.date_year   = r_c;
                n_res.date_month  = r_mon;
                n_res.date_day    = r_day;
                n_res.date_hour   = r_hr;
                n_res.date_minute = r_acc[5:0];
            end
        end
        if (i_cmd.finish_err) begin
            n_res             = '0;
            n_res.range_error = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_item.kind;
            r_yin  <= (i_item.year == 14'd0) ? 14'd1 :
                      ((i_item.year > 14'(CMC_MAX_YEAR)) ? 14'(CMC_MAX_YEAR) : i_item.year);
            r_min  <= (i_item.month == 4'd0) ? 4'd1 :
                      ((i_item.month > 4'd12) ? 4'd12 : i_item.month);
            r_din  <= (i_item.day == 5'd0) ? 5'd1 : i_item.day;
            r_hin  <= (i_item.hour > 5'd23) ? 5'd23 : i_item.hour;
            r_mnin <= (i_item.minute > 6'd59) ? 6'd59 : i_item.minute;
            r_acc  <= i_item.kind ? i_item.total_minutes : 33'd0;
            r_base <= 14'd0;
            r_k    <= '0;
            r_m100 <= 7'd0;
            r_m400 <= 9'd0;
            r_mon  <= 4'd1;
            r_day  <= 5'd1;
            r_hr   <= 5'd0;
        end
        if (i_cmd.blk_step) begin
            r_base <= w_base_nxt[13:0];
            r_k    <= r_k + 1'b1;
            r_m100 <= (w_m100_sum >= 8'd100) ? 7'(w_m100_sum - 8'd100) : w_m100_sum[6:0];
            r_m400 <= (w_m400_sum >= 10'd400) ? 9'(w_m400_sum - 10'd400) : w_m400_sum[8:0];
        end
        if (i_cmd.year_init) begin
            r_acc <= r_kind ? (r_acc - w_blk_off[r_k]) : w_blk_off[r_k];
            // the first block starts at year 1, not year 0
            if (r_base == 14'd0) begin
                r_c    <= 14'd1;
                r_m100 <= 7'd1;
                r_m400 <= 9'd1;
            end else begin
                r_c <= r_base;
            end
        end
        if (i_cmd.year_step) begin
            r_acc  <= r_kind ? (r_acc - 33'(w_ym)) : (r_acc + 33'(w_ym));
            r_c    <= r_c + 14'd1;
            r_m100 <= (r_m100 == 7'd99) ? 7'd0 : r_m100 + 7'd1;
            r_m400 <= (r_m400 == 9'd399) ? 9'd0 : r_m400 + 9'd1;
        end
        if (i_cmd.mon_add) begin
            r_acc <= r_acc + 33'(cmc_cum_min(w_leap, r_min - 4'd1));
        end
        if (i_cmd.mon_step) begin
            r_acc <= r_acc - 33'(w_mlen);
            r_mon <= r_mon + 4'd1;
        end
        if (i_cmd.dhm_add) begin
            r_acc <= r_acc + w_dhm;
        end
        if (i_cmd.day_step) begin
            r_acc <= r_acc - 33'(CMC_MIN_PER_DAY);
            r_day <= r_day + 5'd1;
        end
        if (i_cmd.hour_step) begin
            r_acc <= r_acc - 33'(CMC_MIN_PER_HOUR);
            r_hr  <= r_hr + 5'd1;
        end
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish || i_cmd.finish_err;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

@@ rtl/calendar_minute_converter_top.sv @@
`timescale 1ns / 1ps
// Time from the accepting edge to o_done grows with the blocks and years stepped for date to
//   minutes, and with the blocks, years, months, days and hours for minutes to date; a range
//   error ends the run at the block scan. The year loop steps one year per cycle.
// Throughput: one conversion at a time; the next start is taken in the o_done cycle, once
//   busy has fallen. o_done is high for one cycle, o_result then holds until the next result;
// the receiver cannot stall. Reset (synchronous, active low) returns the sequencer to idle and clears o_done.
// ----------------------------------------------------------------------------
// calendar_minute_converter_top
// Converts a Gregorian date and time to a minute count since year 1, or back.
// ----------------------------------------------------------------------------
module calendar_minute_converter_top
    import cmc_pkg::*;
#(
    parameter int unsigned BLOCK_YEARS = CMC_BLOCK_YEARS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_cmc_in  i_item,
    output logic     o_done,
    output t_cmc_out o_result
);

    t_cmc_cmd w_cmd;
    t_cmc_sts w_sts;

    cmc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    cmc_dp #(
        .BLOCK_YEARS (BLOCK_YEARS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // an accepted transfer keeps the sequencer working in the next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) && !busy))
        else $error("result strobe without a conversion in flight");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.range_error) |->
            (o_result.date_year == 14'd0 && o_result.minutes_count == 33'd0))
        else $error("range error result carries data");

endmodule
